/* design/vrd_pkg.sv */
// ----------------------------------------------------------------------------
// vrd_pkg: shared types and constants of the velocity ramp drive controller
// Item, result and register layouts, request kinds and output codes.
// ----------------------------------------------------------------------------
package vrd_pkg;

  // request kinds
  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_ESTOP  = 2'd2;

  // motor direction codes
  localparam logic [1:0] DIR_STOP    = 2'd0;
  localparam logic [1:0] DIR_FWD     = 2'd1;
  localparam logic [1:0] DIR_BWD     = 2'd2;

  // steering servo codes
  localparam logic [1:0] STEER_MID   = 2'd0;
  localparam logic [1:0] STEER_LEFT  = 2'd1;
  localparam logic [1:0] STEER_RIGHT = 2'd2;

  // register indexes on the apb port
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd0;
  localparam logic [1:0] REG_SPEED_STEP  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT     = 2'd2;
  localparam logic [1:0] REG_DEADBAND    = 2'd3;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [14:0] SPEED_LIMIT_RST = 15'd4096;
  localparam logic [14:0] SPEED_STEP_RST  = 15'd205;
  localparam logic [15:0] TIMEOUT_RST     = 16'd10;
  localparam logic [14:0] DEADBAND_RST    = 15'd410;

  // pwm full scale and q3.12 fraction bits
  localparam logic [6:0]  PWM_FULL = 7'd100;
  localparam int unsigned Q_SHIFT  = 12;

  typedef struct packed {
    logic [14:0] speed_limit;
    logic [14:0] speed_step;
    logic [15:0] timeout_ticks;
    logic [14:0] steer_deadband;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] linear_cmd;
    logic [15:0] angular_cmd;
    logic        engage;
  } item_t;

  typedef struct packed {
    logic [1:0]  direction;
    logic [6:0]  speed;
    logic [1:0]  steer;
    logic [15:0] current_velocity;
    logic        stop_active;
  } result_t;

endpackage

/* design/velocity_ramp_drive_controller.sv */
// ----------------------------------------------------------------------------
// velocity_ramp_drive_controller: slew-limited drive controller
// Each request (velocity command, control tick or emergency stop) gives one
// result carrying direction, pwm speed, steering, ramped velocity and stop
// state as they stand after the request. Requests pass an input register,
// one combinational update of the drive state, and a result register, so a
// request is taken every cycle while in_stall_o is low; the result register
// frees while a result waits only when the receiver takes it. The user must
// write registers over the apb port while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module velocity_ramp_drive_controller
  import vrd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        kind_i,
  input  logic signed [15:0] linear_cmd_i,
  input  logic signed [15:0] angular_cmd_i,
  input  logic              engage_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        direction_o,
  output logic [6:0]        speed_o,
  output logic [1:0]        steer_o,
  output logic signed [15:0] current_velocity_o,
  output logic              stop_active_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    accept;
  logic    advance;

  vrd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the held request moves on once the result register is free
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind        <= kind_i;
      item_q.linear_cmd  <= linear_cmd_i;
      item_q.angular_cmd <= angular_cmd_i;
      item_q.engage      <= engage_i;
    end
  end

  vrd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (advance),
    .item_i (item_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign direction_o        = res_q.direction;
  assign speed_o            = res_q.speed;
  assign steer_o            = res_q.steer;
  assign current_velocity_o = res_q.current_velocity;
  assign stop_active_o      = res_q.stop_active;

  ast_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced request lost before result register");

  ast_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("request channel stalled without a blocked result");

  ast_stop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.stop_active) |->
      (res_q.direction == DIR_STOP && res_q.speed == 7'd0 && res_q.steer == STEER_MID))
    else $error("result drives motors during emergency stop");

endmodule

/* design/vrd_cfg.sv */
// ----------------------------------------------------------------------------
// vrd_cfg: configuration registers
// APB-style register file holding clamp, slew step, watchdog and deadband.
// ----------------------------------------------------------------------------
module vrd_cfg
  import vrd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_limit    <= SPEED_LIMIT_RST;
      cfg_q.speed_step     <= SPEED_STEP_RST;
      cfg_q.timeout_ticks  <= TIMEOUT_RST;
      cfg_q.steer_deadband <= DEADBAND_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SPEED_LIMIT: cfg_q.speed_limit    <= pwdata[14:0];
        REG_SPEED_STEP:  cfg_q.speed_step     <= pwdata[14:0];
        REG_TIMEOUT:     cfg_q.timeout_ticks  <= pwdata[15:0];
        REG_DEADBAND:    cfg_q.steer_deadband <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SPEED_LIMIT: prdata = {17'd0, cfg_q.speed_limit};
      REG_SPEED_STEP:  prdata = {17'd0, cfg_q.speed_step};
      REG_TIMEOUT:     prdata = {16'd0, cfg_q.timeout_ticks};
      REG_DEADBAND:    prdata = {17'd0, cfg_q.steer_deadband};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* design/vrd_core.sv */
// ----------------------------------------------------------------------------
// vrd_core: drive state and per-request update
// Holds targets, ramp, watchdog and outputs; computes the state after one
// request in a single combinational pass.
// ----------------------------------------------------------------------------
module vrd_core
  import vrd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t res_o
);

  logic [15:0] tgt_lin_q, tgt_lin_d;
  logic [15:0] tgt_ang_q, tgt_ang_d;
  logic [15:0] ramp_q, ramp_d;
  logic [15:0] idle_q, idle_d;
  logic        stop_q, stop_d;
  logic [1:0]  dir_q, dir_d;
  logic [6:0]  spd_q, spd_d;
  logic [1:0]  steer_q, steer_d;

  // command clamp
  logic signed [17:0] lin_cmd, max_pos, max_neg;
  logic [15:0]        lin_clamped;

  // tick path
  logic [15:0]        idle_inc;
  logic               wd_trip;
  logic [15:0]        tl, ta;
  logic signed [17:0] r_s, t_s, step_s, n_up, n_dn, nr_s;
  logic [15:0]        nr;
  logic [15:0]        abs_r;
  logic [22:0]        prod;
  logic [10:0]        mag_raw;
  logic [6:0]         mag;
  logic signed [17:0] ang_s, lim_pos, lim_neg;

  always_comb begin
    lin_cmd = 18'(signed'(item_i.linear_cmd));
    max_pos = signed'({3'd0, cfg_i.speed_limit});
    max_neg = -max_pos;
    if (lin_cmd > max_pos) begin
      lin_clamped = max_pos[15:0];
    end else if (lin_cmd < max_neg) begin
      lin_clamped = max_neg[15:0];
    end else begin
      lin_clamped = item_i.linear_cmd;
    end
  end

  always_comb begin
    idle_inc = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
    wd_trip  = idle_inc > cfg_i.timeout_ticks;
    tl       = wd_trip ? 16'd0 : tgt_lin_q;
    ta       = wd_trip ? 16'd0 : tgt_ang_q;

    // slew toward the target, never past it
    r_s    = 18'(signed'(ramp_q));
    t_s    = 18'(signed'(tl));
    step_s = signed'({3'd0, cfg_i.speed_step});
    n_up   = r_s + step_s;
    n_dn   = r_s - step_s;
    if (r_s < t_s) begin
      nr_s = (n_up < t_s) ? n_up : t_s;
    end else begin
      nr_s = (n_dn > t_s) ? n_dn : t_s;
    end
    nr = nr_s[15:0];

    // pwm = floor(|v| * 100 / 4096), saturated
    abs_r   = nr_s[17] ? 16'(-nr_s) : nr;
    prod    = 23'(abs_r) * 23'(PWM_FULL);
    mag_raw = prod[22:Q_SHIFT];
    mag     = (mag_raw > 11'(PWM_FULL)) ? PWM_FULL : mag_raw[6:0];

    ang_s   = 18'(signed'(ta));
    lim_pos = signed'({3'd0, cfg_i.steer_deadband});
    lim_neg = -lim_pos;
  end

  always_comb begin
    tgt_lin_d = tgt_lin_q;
    tgt_ang_d = tgt_ang_q;
    ramp_d    = ramp_q;
    idle_d    = idle_q;
    stop_d    = stop_q;
    dir_d     = dir_q;
    spd_d     = spd_q;
    steer_d   = steer_q;
    case (item_i.kind)
      KIND_CMD: begin
        tgt_lin_d = lin_clamped;
        tgt_ang_d = item_i.angular_cmd;
        idle_d    = 16'd0;
      end
      KIND_TICK: begin
        idle_d    = idle_inc;
        tgt_lin_d = tl;
        tgt_ang_d = ta;
        ramp_d    = nr;
        if (stop_q || mag == 7'd0) begin
          dir_d = DIR_STOP;
          spd_d = 7'd0;
        end else if (nr_s > 18'sd0) begin
          dir_d = DIR_FWD;
          spd_d = mag;
        end else begin
          dir_d = DIR_BWD;
          spd_d = mag;
        end
        // steering frozen while stopped
        if (!stop_q) begin
          if (ang_s > lim_pos) begin
            steer_d = STEER_LEFT;
          end else if (ang_s < lim_neg) begin
            steer_d = STEER_RIGHT;
          end else begin
            steer_d = STEER_MID;
          end
        end
      end
      KIND_ESTOP: begin
        stop_d = item_i.engage;
        if (item_i.engage) begin
          dir_d   = DIR_STOP;
          spd_d   = 7'd0;
          steer_d = STEER_MID;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_lin_q <= '0;
      tgt_ang_q <= '0;
      ramp_q    <= '0;
      idle_q    <= '0;
      stop_q    <= 1'b0;
      dir_q     <= DIR_STOP;
      spd_q     <= '0;
      steer_q   <= STEER_MID;
    end else if (fire_i) begin
      tgt_lin_q <= tgt_lin_d;
      tgt_ang_q <= tgt_ang_d;
      ramp_q    <= ramp_d;
      idle_q    <= idle_d;
      stop_q    <= stop_d;
      dir_q     <= dir_d;
      spd_q     <= spd_d;
      steer_q   <= steer_d;
    end
  end

  assign res_o.direction        = dir_d;
  assign res_o.speed            = spd_d;
  assign res_o.steer            = steer_d;
  assign res_o.current_velocity = ramp_d;
  assign res_o.stop_active      = stop_d;

  ast_speed_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spd_q <= PWM_FULL)
    else $error("drive speed above full scale");

  ast_stop_holds_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |-> (dir_q == DIR_STOP && spd_q == 7'd0 && steer_q == STEER_MID))
    else $error("motor or steering active during emergency stop");

  ast_dir_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dir_q == DIR_STOP) == (spd_q == 7'd0))
    else $error("direction and speed disagree");

endmodule
